[rtl/gesr_pkg.sv]
// gesr_pkg: shared types and constants for the graph edge store
// request kinds, status codes, controller/datapath command and status structs
// no dependencies
package gesr_pkg;

    localparam int VERTICES_DEF = 16;
    localparam int TYPE_W       = 3;
    localparam int ID_W         = 4;
    localparam int STATUS_W     = 2;
    localparam int TOTAL_W      = 5;

    typedef enum logic [TYPE_W-1:0] {
        REQ_ADD_VERTEX = 3'd0,
        REQ_DEL_VERTEX = 3'd1,
        REQ_ADD_EDGE   = 3'd2,
        REQ_DEL_EDGE   = 3'd3,
        REQ_CLR_VERTEX = 3'd4,
        REQ_CLR_EDGES  = 3'd5,
        REQ_CLR_GRAPH  = 3'd6,
        REQ_QUERY      = 3'd7
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic walk_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_start;
        logic walk_done;
    } dp_stat_t;

endpackage

[rtl/gesr_if.sv]
// gesr_req_if, gesr_rsp_if: valid/ready channels for requests and results
// depends on gesr_pkg
interface gesr_req_if;
    import gesr_pkg::*;

    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] req_type;
    logic [ID_W-1:0]   vertex_a;
    logic [ID_W-1:0]   vertex_b;

    modport source (output valid, output req_type, output vertex_a, output vertex_b,
                    input ready);
    modport sink   (input valid, input req_type, input vertex_a, input vertex_b,
                    output ready);
endinterface

interface gesr_rsp_if;
    import gesr_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                is_connected;
    logic [ID_W-1:0]     new_vertex_id;
    logic [TOTAL_W-1:0]  vertex_total;

    modport source (output valid, output status, output is_connected,
                    output new_vertex_id, output vertex_total, input ready);
    modport sink   (input valid, input status, input is_connected,
                    input new_vertex_id, input vertex_total, output ready);
endinterface

[rtl/gesr_ctrl.sv]
// gesr_ctrl: request sequencer (capture, execute, walk, respond) and output valid
// depends on gesr_pkg
module gesr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_ready,
    output logic               out_valid,
    input  gesr_pkg::dp_stat_t stat,
    output gesr_pkg::dp_cmd_t  cmd
);
    import gesr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WALK = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.walk_start ? S_WALK : S_RESP;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/gesr_dp.sv]
// gesr_dp: adjacency matrix, vertex count, walk masks and result registers
// depends on gesr_pkg; driven by gesr_ctrl commands
module gesr_dp #(
    parameter int VERTICES = gesr_pkg::VERTICES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gesr_pkg::dp_cmd_t             cmd,
    output gesr_pkg::dp_stat_t            stat,
    input  logic [gesr_pkg::TYPE_W-1:0]   req_type,
    input  logic [gesr_pkg::ID_W-1:0]     vertex_a,
    input  logic [gesr_pkg::ID_W-1:0]     vertex_b,
    output logic [gesr_pkg::STATUS_W-1:0] status,
    output logic                          is_connected,
    output logic [gesr_pkg::ID_W-1:0]     new_vertex_id,
    output logic [gesr_pkg::TOTAL_W-1:0]  vertex_total
);
    import gesr_pkg::*;

    localparam int CW = $clog2(VERTICES + 1);
    localparam int IW = $clog2(VERTICES);
    localparam int XW = (CW > ID_W) ? CW : ID_W;

    typedef logic [VERTICES-1:0] row_t;

    req_kind_t          kind_reg;
    logic [ID_W-1:0]    a_reg;
    logic [ID_W-1:0]    b_reg;
    row_t               rows_reg [VERTICES];
    row_t               rows_next [VERTICES];
    row_t               rows_up [VERTICES];
    logic [CW-1:0]      total_reg;
    logic [CW-1:0]      total_next;
    row_t               visited_reg;
    row_t               visited_next;
    row_t               frontier_reg;
    row_t               frontier_next;
    status_t            res_status_reg;
    status_t            res_status_next;
    logic               res_conn_reg;
    logic               res_conn_next;
    logic [ID_W-1:0]    res_id_reg;
    logic [ID_W-1:0]    res_id_next;
    status_t            out_status_reg;
    logic               out_conn_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    logic [XW-1:0]      a_x;
    logic [XW-1:0]      b_x;
    logic [XW-1:0]      total_x;
    logic               a_ok;
    logic               b_ok;
    logic               id_err;
    logic [IW-1:0]      a_idx;
    logic [IW-1:0]      b_idx;
    row_t               a_hot;
    row_t               b_hot;
    row_t               total_hot;
    row_t               reach;
    row_t               walk_new;
    row_t               walk_vis;
    logic               walk_hit;

    // drop bit pos and move higher bits down
    function automatic row_t squeeze(input row_t m, input logic [IW-1:0] pos);
        row_t low_mask;
        low_mask = (row_t'(1) << pos) - row_t'(1);
        return (m & low_mask) | ((m >> 1) & ~low_mask);
    endfunction

    genvar g;
    generate
        for (g = 0; g < VERTICES; g++)
        begin : g_up
            if (g < VERTICES - 1)
            begin : g_mid
                assign rows_up[g] = rows_reg[g + 1];
            end
            else
            begin : g_last
                assign rows_up[g] = '0;
            end
        end
    endgenerate

    assign a_x       = XW'(a_reg);
    assign b_x       = XW'(b_reg);
    assign total_x   = XW'(total_reg);
    assign a_ok      = a_x < total_x;
    assign b_ok      = b_x < total_x;
    assign a_idx     = a_x[IW-1:0];
    assign b_idx     = b_x[IW-1:0];
    assign a_hot     = row_t'(1) << a_idx;
    assign b_hot     = row_t'(1) << b_idx;
    assign total_hot = row_t'(1) << total_reg;

    always_comb
    begin
        unique case (kind_reg)
            REQ_DEL_VERTEX, REQ_CLR_VERTEX:
            begin
                id_err = !a_ok;
            end
            REQ_ADD_EDGE, REQ_DEL_EDGE, REQ_QUERY:
            begin
                id_err = !(a_ok && b_ok);
            end
            default:
            begin
                id_err = 1'b0;
            end
        endcase
    end

    // one frontier expansion
    always_comb
    begin
        reach = '0;
        for (int i = 0; i < VERTICES; i++)
        begin
            if (frontier_reg[i])
            begin
                reach = reach | rows_reg[i];
            end
        end
    end

    assign walk_new = reach & ~visited_reg;
    assign walk_vis = visited_reg | walk_new;
    assign walk_hit = walk_vis[b_idx];

    assign stat.walk_start = (kind_reg == REQ_QUERY) && !id_err && (a_reg != b_reg);
    assign stat.walk_done  = walk_hit || (walk_new == '0);

    always_comb
    begin
        rows_next       = rows_reg;
        total_next      = total_reg;
        visited_next    = visited_reg;
        frontier_next   = frontier_reg;
        res_status_next = res_status_reg;
        res_conn_next   = res_conn_reg;
        res_id_next     = res_id_reg;
        if (cmd.exec)
        begin
            res_status_next = ST_OK;
            res_conn_next   = 1'b0;
            res_id_next     = '0;
            if (id_err)
            begin
                res_status_next = ST_RANGE;
            end
            else
            begin
                unique case (kind_reg)
                    REQ_ADD_VERTEX:
                    begin
                        if (total_reg >= CW'(VERTICES))
                        begin
                            res_status_next = ST_REJECT;
                        end
                        else
                        begin
                            for (int i = 0; i < VERTICES; i++)
                            begin
                                rows_next[i] = total_hot[i] ? '0 : (rows_reg[i] & ~total_hot);
                            end
                            res_id_next = ID_W'(total_reg);
                            total_next  = total_reg + 1'b1;
                        end
                    end
                    REQ_DEL_VERTEX:
                    begin
                        for (int i = 0; i < VERTICES; i++)
                        begin
                            if (i + 1 < int'(total_reg))
                            begin
                                rows_next[i] = squeeze((i < int'(a_idx)) ? rows_reg[i]
                                                                         : rows_up[i], a_idx);
                            end
                            else if (i + 1 == int'(total_reg))
                            begin
                                rows_next[i] = '0;
                            end
                        end
                        total_next = total_reg - 1'b1;
                    end
                    REQ_ADD_EDGE:
                    begin
                        if (rows_reg[a_idx][b_idx])
                        begin
                            res_status_next = ST_REJECT;
                        end
                        else
                        begin
                            for (int i = 0; i < VERTICES; i++)
                            begin
                                rows_next[i] = rows_reg[i] | (a_hot[i] ? b_hot : '0)
                                                           | (b_hot[i] ? a_hot : '0);
                            end
                        end
                    end
                    REQ_DEL_EDGE:
                    begin
                        for (int i = 0; i < VERTICES; i++)
                        begin
                            rows_next[i] = rows_reg[i] & ~(a_hot[i] ? b_hot : '0)
                                                       & ~(b_hot[i] ? a_hot : '0);
                        end
                    end
                    REQ_CLR_VERTEX:
                    begin
                        for (int i = 0; i < VERTICES; i++)
                        begin
                            rows_next[i] = a_hot[i] ? '0 : (rows_reg[i] & ~a_hot);
                        end
                    end
                    REQ_CLR_EDGES:
                    begin
                        for (int i = 0; i < VERTICES; i++)
                        begin
                            rows_next[i] = '0;
                        end
                    end
                    REQ_CLR_GRAPH:
                    begin
                        for (int i = 0; i < VERTICES; i++)
                        begin
                            rows_next[i] = '0;
                        end
                        total_next = '0;
                    end
                    REQ_QUERY:
                    begin
                        if (a_reg == b_reg)
                        begin
                            res_conn_next = 1'b1;
                        end
                        else
                        begin
                            visited_next  = a_hot;
                            frontier_next = a_hot;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
        end
        else if (cmd.walk_step)
        begin
            visited_next  = walk_vis;
            frontier_next = walk_new;
            res_conn_next = walk_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VERTICES; i++)
            begin
                rows_reg[i] <= '0;
            end
            total_reg    <= '0;
            visited_reg  <= '0;
            frontier_reg <= '0;
        end
        else
        begin
            rows_reg     <= rows_next;
            total_reg    <= total_next;
            visited_reg  <= visited_next;
            frontier_reg <= frontier_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= req_kind_t'(req_type);
            a_reg    <= vertex_a;
            b_reg    <= vertex_b;
        end
        res_status_reg <= res_status_next;
        res_conn_reg   <= res_conn_next;
        res_id_reg     <= res_id_next;
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_conn_reg   <= res_conn_reg;
            out_id_reg     <= res_id_reg;
            out_total_reg  <= TOTAL_W'(total_reg);
        end
    end

    assign status        = out_status_reg;
    assign is_connected  = out_conn_reg;
    assign new_vertex_id = out_id_reg;
    assign vertex_total  = out_total_reg;

endmodule

[rtl/graph_edge_store_reachability.sv]
// graph_edge_store_reachability: undirected graph store with reachability queries
// depends on gesr_pkg, gesr_if, gesr_ctrl, gesr_dp
//
// requests arrive on req (req_type, vertex_a, vertex_b), one result per request
// leaves on rsp (status, is_connected, new_vertex_id, vertex_total); both channels
// are valid/ready and move an item on a clock edge with valid and ready high
// one request is worked at a time: req.ready is high only while the block is idle
// a request is captured and executed against the adjacency matrix; after any walk
// its result is written to the output register once the output slot is free
// plain requests pass in turn through the capture, execute and respond states
// queries with distinct ids add a breadth-first walk of at most VERTICES-1 frontier
// expansions, ending when the target is reached or the frontier empties; each
// expansion ORs together the adjacency rows of the frontier vertices
// the output register holds a result while rsp.ready is low; the block may take
// the next request meanwhile and waits before writing its result until the slot frees
// reset (rst_n low, asynchronous) empties the graph: no vertices, no edges
module graph_edge_store_reachability #(
    parameter int VERTICES = gesr_pkg::VERTICES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    gesr_req_if.sink  req,
    gesr_rsp_if.source rsp
);
    import gesr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;
    logic     out_valid;

    gesr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_ready (rsp.ready),
        .out_valid (out_valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    gesr_dp #(
        .VERTICES (VERTICES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req.req_type),
        .vertex_a      (req.vertex_a),
        .vertex_b      (req.vertex_b),
        .status        (rsp.status),
        .is_connected  (rsp.is_connected),
        .new_vertex_id (rsp.new_vertex_id),
        .vertex_total  (rsp.vertex_total)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

`ifndef SYNTHESIS
    a_conn_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.is_connected) |-> (rsp.status == ST_OK))
        else $error("connected answer with error status");

    a_id_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.new_vertex_id != '0)) |-> (rsp.status == ST_OK))
        else $error("new vertex id on failed request");

    a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (int'(rsp.vertex_total) <= VERTICES))
        else $error("vertex count above capacity");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> rsp.valid)
        else $error("loaded result not presented");
`endif

endmodule
